### rtl/core/pris_pkg.sv
// package for the predicated instruction step unit
// shared types, field masks, operation and fault codes; no dependencies
`default_nettype none

package pris_pkg;

  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned REG_AW   = $clog2(NUM_REGS);
  localparam int unsigned PRED_W   = 8;
  localparam int unsigned PRED_AW  = $clog2(PRED_W);

  localparam logic [31:0] MAJOR_MASK  = 32'h00C0_0000;
  localparam logic [31:0] MAJOR_UPPER = 32'h00C0_0000;
  localparam logic [31:0] MAJOR_LUI   = 32'h0080_0000;
  localparam logic [31:0] MAJOR_JUMP  = 32'h0040_0000;
  localparam logic [31:0] CLASS_MASK  = 32'h0030_0800;
  localparam logic [31:0] CLASS_STORE = 32'h0030_0800;
  localparam logic [31:0] CLASS_CMP   = 32'h0020_0000;
  localparam logic [31:0] CLASS_MISC  = 32'h0020_0800;
  localparam logic [31:0] ARITH_MASK  = 32'h001F_0800;
  localparam logic [31:0] ARITH_ADD   = 32'h0000_0000;
  localparam logic [31:0] ARITH_SUB   = 32'h0001_0000;
  localparam logic [31:0] ARITH_AND   = 32'h0002_0000;
  localparam logic [31:0] ARITH_SHR   = 32'h0006_0000;
  localparam logic [31:0] IMM_FLAG    = 32'h0000_0400;

  localparam logic [3:0] CMP_GTU = 4'd0;
  localparam logic [3:0] CMP_GTS = 4'd1;
  localparam logic [3:0] CMP_EQ  = 4'd2;
  localparam logic [3:0] CMP_BIT = 4'd3;
  localparam logic [3:0] MISC_JR = 4'd0;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_UNSUP   = 2'd1;
  localparam logic [1:0] FAULT_ALIGN   = 2'd2;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        executed;
    logic        store_valid;
    logic [31:0] store_address;
    logic [31:0] store_data;
    logic [1:0]  fault;
  } res_t;

  typedef struct packed {
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata;
    logic [PRED_W-1:0] pred_nxt;
  } wb_t;

endpackage

`default_nettype wire

### rtl/core/pris_in_if.sv
// input channel of the step unit: one instruction word per item
// valid/ready handshake, no package dependency
`default_nettype none

interface pris_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

`default_nettype wire

### rtl/core/pris_out_if.sv
// result channel of the step unit: next pc, store request and fault per item
// valid/ready handshake, no package dependency
`default_nettype none

interface pris_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        executed;
  logic        store_valid;
  logic [31:0] store_address;
  logic [31:0] store_data;
  logic [1:0]  fault;

  modport source (output valid, output next_pc, output executed, output store_valid,
                  output store_address, output store_data, output fault, input ready);
  modport sink   (input valid, input next_pc, input executed, input store_valid,
                  input store_address, input store_data, input fault, output ready);
endinterface

`default_nettype wire

### rtl/core/pris_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pris_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pris_regfile.sv
// register file: three ram copies for operand a, operand b and store data
// per-entry valid bits give zero after reset, write bypass for same-edge reads
// depends on pris_pkg and pris_ram
`default_nettype none

module pris_regfile (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [pris_pkg::REG_AW-1:0] rd_addr [3],
  input  wire logic                      wr_en,
  input  wire logic [pris_pkg::REG_AW-1:0] wr_addr,
  input  wire logic [31:0]               wr_data,
  output logic      [31:0]               rd_data [3]
);
  import pris_pkg::*;

  logic [NUM_REGS-1:0] valid_r;
  logic [31:0]         wdata_r;
  logic [31:0]         ram_q [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wdata_r <= wr_data;
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_port
    logic byp_r;
    logic vld_r;

    pris_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[p]),
      .rd_data (ram_q[p])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        byp_r <= 1'b0;
        vld_r <= 1'b0;
      end else if (rd_en) begin
        byp_r <= wr_en && (wr_addr == rd_addr[p]);
        vld_r <= valid_r[rd_addr[p]];
      end
    end

    assign rd_data[p] = byp_r ? wdata_r : (vld_r ? ram_q[p] : '0);
  end

endmodule

`default_nettype wire

### rtl/core/pris_exec.sv
// decode and execute of one instruction word against the current state
// produces the result item and the state write-back; depends on pris_pkg
`default_nettype none

module pris_exec (
  input  wire logic [31:0]                 ins,
  input  wire logic [31:0]                 pc,
  input  wire logic [pris_pkg::PRED_W-1:0] pred,
  input  wire logic [31:0]                 reg_a,
  input  wire logic [31:0]                 reg_b,
  input  wire logic [31:0]                 reg_s,
  output pris_pkg::res_t                   res,
  output pris_pkg::wb_t                    wb
);
  import pris_pkg::*;

  logic [31:0]        pc4;
  logic [31:0]        b;
  logic [31:0]        sum;
  logic [3:0]         rd;
  logic [3:0]         func;
  logic [31:0]        cls;
  logic [31:0]        arith;
  logic [PRED_AW-1:0] pd;
  logic               cmp_res;
  logic               cmp_ok;
  logic [15:0]        a16;
  logic [15:0]        b16;

  assign pc4   = pc + 32'd4;
  assign b     = ((ins & IMM_FLAG) != '0) ? {{22{ins[9]}}, ins[9:0]} : reg_b;
  assign sum   = reg_a + b;
  assign rd    = ins[27:24];
  assign func  = ins[19:16];
  assign cls   = ins & CLASS_MASK;
  assign arith = ins & ARITH_MASK;
  assign pd    = rd[PRED_AW-1:0];
  assign a16   = {~reg_a[15], reg_a[14:0]};
  assign b16   = {~b[15], b[14:0]};

  always_comb begin
    cmp_ok  = 1'b1;
    cmp_res = 1'b0;
    unique case (func)
      CMP_GTU: cmp_res = reg_a > b;
      CMP_GTS: cmp_res = a16 > b16;
      CMP_EQ:  cmp_res = reg_a == b;
      CMP_BIT: cmp_res = reg_a[b[4:0]];
      default: cmp_ok  = 1'b0;
    endcase
  end

  always_comb begin
    res          = '0;
    res.executed = 1'b1;
    res.next_pc  = pc;
    res.fault    = FAULT_NONE;
    wb.rf_we     = 1'b0;
    wb.rf_waddr  = rd;
    wb.rf_wdata  = pc4;
    wb.pred_nxt  = pred;

    if (pred[ins[30:28]] ^ ins[31]) begin
      res.executed = 1'b0;
      res.next_pc  = pc4;
    end else if ((ins & MAJOR_MASK) == MAJOR_UPPER) begin
      res.fault = FAULT_UNSUP;
    end else if ((ins & MAJOR_MASK) == MAJOR_LUI) begin
      wb.rf_we    = rd != '0;
      wb.rf_wdata = {ins[21:0], 10'd0};
      res.next_pc = pc4;
    end else if ((ins & MAJOR_MASK) == MAJOR_JUMP) begin
      wb.rf_we    = rd != '0;
      res.next_pc = pc + {{8{ins[21]}}, ins[21:0], 2'b00};
    end else if (cls == CLASS_STORE) begin
      if (rd != '0) begin
        res.fault = FAULT_UNSUP;
      end else if (sum[1:0] != 2'b00) begin
        res.fault = FAULT_ALIGN;
      end else begin
        res.store_valid   = 1'b1;
        res.store_address = sum;
        res.store_data    = reg_s;
        res.next_pc       = pc4;
      end
    end else if (cls == CLASS_CMP) begin
      if (!cmp_ok) begin
        res.fault = FAULT_UNSUP;
      end else begin
        if (pd != '0) begin
          wb.pred_nxt[pd] = cmp_res ^ rd[3];
        end
        res.next_pc = pc4;
      end
    end else if (cls == CLASS_MISC) begin
      if (func != MISC_JR) begin
        res.fault = FAULT_UNSUP;
      end else begin
        wb.rf_we    = rd != '0;
        res.next_pc = sum;
      end
    end else begin
      wb.rf_we    = rd != '0;
      res.next_pc = pc4;
      case (arith)
        ARITH_ADD: wb.rf_wdata = sum;
        ARITH_SUB: wb.rf_wdata = reg_a - b;
        ARITH_AND: wb.rf_wdata = reg_a & b;
        ARITH_SHR: wb.rf_wdata = reg_a >> b[4:0];
        default: begin
          wb.rf_we    = 1'b0;
          res.next_pc = pc;
          res.fault   = FAULT_UNSUP;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/predicated_risc_instruction_step_unit.sv
// top level of the predicated instruction step unit
// depends on pris_pkg, pris_in_if, pris_out_if, pris_regfile and pris_exec
//
// usage: each item on in_ch is one instruction word fetched at the current
// program counter. the unit executes it against its 16 registers, 8 predicate
// bits and pc, and returns one item on out_ch with the next pc, an executed
// flag, an optional aligned word store request and a fault code.
// an accepted item is held in an input register while its operands are read
// from the register file rams; it executes once the output register is free
// and lands in the output register. throughput is one item per clock while
// out_ch does not stall: the next item is taken in the same cycle as the
// current one executes, and state written by one item is forwarded to the
// operand reads of the next.
// a stalled receiver holds the output register; one further item may wait in
// the input register, after which in_ch.ready drops until out_ch moves.
// reset (rst_n low, synchronous) empties both registers, clears all registers
// and predicates to zero and sets the pc to RESET_PC. no clearing pass.
`default_nettype none

module predicated_risc_instruction_step_unit #(
  parameter logic [31:0] RESET_PC = 32'h0000_8000
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pris_in_if.sink   in_ch,
  pris_out_if.source out_ch
);
  import pris_pkg::*;

  logic              in_valid_r;
  logic [31:0]       instr_r;
  logic              out_valid_r;
  res_t              res_r;
  logic [31:0]       pc_r;
  logic [PRED_W-1:0] pred_r;
  logic              in_fire;
  logic              exec_fire;
  logic [REG_AW-1:0] rd_addr [3];
  logic [31:0]       rd_data [3];
  res_t              res;
  wb_t               wb;

  assign exec_fire   = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || exec_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign rd_addr[0] = in_ch.instruction[15:12];
  assign rd_addr[1] = in_ch.instruction[3:0];
  assign rd_addr[2] = in_ch.instruction[19:16];

  pris_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .wr_en   (exec_fire && wb.rf_we),
    .wr_addr (wb.rf_waddr),
    .wr_data (wb.rf_wdata),
    .rd_data (rd_data)
  );

  pris_exec u_exec (
    .ins   (instr_r),
    .pc    (pc_r),
    .pred  (pred_r),
    .reg_a (rd_data[0]),
    .reg_b (rd_data[1]),
    .reg_s (rd_data[2]),
    .res   (res),
    .wb    (wb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= RESET_PC;
      pred_r      <= '0;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (exec_fire) begin
        in_valid_r <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
        pc_r        <= res.next_pc;
        pred_r      <= wb.pred_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      instr_r <= in_ch.instruction;
    end
    if (exec_fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_pc       = res_r.next_pc;
  assign out_ch.executed      = res_r.executed;
  assign out_ch.store_valid   = res_r.store_valid;
  assign out_ch.store_address = res_r.store_address;
  assign out_ch.store_data    = res_r.store_data;
  assign out_ch.fault         = res_r.fault;

  a_store_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.store_valid |-> res_r.fault == FAULT_NONE && res_r.executed)
    else $error("store request with fault or skip");

  a_fault_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && res.fault != FAULT_NONE |=> pc_r == $past(pc_r))
    else $error("pc moved on a faulting item");

  a_skip_advances: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && !res.executed |=> pc_r == $past(pc_r) + 32'd4)
    else $error("skipped item did not advance pc by 4");

  a_p0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    pred_r[0] == 1'b0)
    else $error("predicate p0 written");

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for predicated_risc_instruction_step_unit
// predicts every step (registers, predicates, pc) and compares each result item
// depends on pris_pkg, pris_in_if, pris_out_if and the top level from the rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pris_pkg::*;

  localparam logic [31:0] RESET_ADDR   = 32'h0000_8000;
  localparam logic [3:0]  P_ALWAYS     = 4'b0000;
  localparam logic [3:0]  P_NEVER      = 4'b1000;
  localparam logic [31:0] ARITH_BAD    = 32'h0003_0000;
  localparam logic [31:0] ARITH_BAD_HI = 32'h0010_0000;
  localparam logic [3:0]  CMP_BAD      = 4'd4;
  localparam logic [3:0]  MISC_BAD     = 4'd5;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          LONG_HOLD    = 60;
  localparam int          DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;

  pris_in_if  in_ch ();
  pris_out_if out_ch ();

  predicated_risc_instruction_step_unit #(
    .RESET_PC(RESET_ADDR)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [31:0] gpr [NUM_REGS];
  logic [7:0]  pred_bits;
  logic [31:0] pc_now;

  res_t pending_results[$];
  int   mismatches    = 0;
  int   hold_cycles   = 0;
  int   quiet_cycles  = 0;
  bit   long_hold_req = 1'b0;
  bit   gaps_on       = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void write_gpr(input logic [3:0] idx, input logic [31:0] value);
    if (idx != 4'd0) gpr[idx] = value;
  endfunction

  // executes one instruction word on the local copy of the state
  function automatic res_t execute_instr(input logic [31:0] w);
    res_t        r;
    logic [31:0] a, b, addr, alu, npc;
    logic [3:0]  rd, fn;
    logic        hit, ok;
    r          = '0;
    r.executed = 1'b1;
    r.fault    = FAULT_NONE;
    npc        = pc_now;
    rd         = w[27:24];
    fn         = w[19:16];
    ok         = 1'b1;
    hit        = 1'b0;
    alu        = '0;
    if (pred_bits[w[30:28]] ^ w[31]) begin
      r.executed = 1'b0;
      npc = pc_now + 32'd4;
    end else if ((w & MAJOR_MASK) == MAJOR_UPPER) begin
      r.fault = FAULT_UNSUP;
    end else if ((w & MAJOR_MASK) == MAJOR_LUI) begin
      write_gpr(rd, w << 10);
      npc = pc_now + 32'd4;
    end else if ((w & MAJOR_MASK) == MAJOR_JUMP) begin
      write_gpr(rd, pc_now + 32'd4);
      npc = pc_now + {{8{w[21]}}, w[21:0], 2'b00};
    end else begin
      a = gpr[w[15:12]];
      b = ((w & IMM_FLAG) != 32'h0) ? {{22{w[9]}}, w[9:0]} : gpr[w[3:0]];
      case (w & CLASS_MASK)
        CLASS_STORE: begin
          addr = a + b;
          if (rd != 4'd0) begin
            r.fault = FAULT_UNSUP;
          end else if (addr[1:0] != 2'b00) begin
            r.fault = FAULT_ALIGN;
          end else begin
            r.store_valid   = 1'b1;
            r.store_address = addr;
            r.store_data    = gpr[fn];
            npc = pc_now + 32'd4;
          end
        end
        CLASS_CMP: begin
          case (fn)
            CMP_GTU: hit = a > b;
            CMP_GTS: hit = $signed(a[15:0]) > $signed(b[15:0]);
            CMP_EQ:  hit = a == b;
            CMP_BIT: hit = a[b[4:0]];
            default: ok = 1'b0;
          endcase
          if (!ok) begin
            r.fault = FAULT_UNSUP;
          end else begin
            if (rd[2:0] != 3'd0) pred_bits[rd[2:0]] = hit ^ rd[3];
            npc = pc_now + 32'd4;
          end
        end
        CLASS_MISC: begin
          if (fn != MISC_JR) begin
            r.fault = FAULT_UNSUP;
          end else begin
            write_gpr(rd, pc_now + 32'd4);
            npc = a + b;
          end
        end
        default: begin
          case (w & ARITH_MASK)
            ARITH_ADD: alu = a + b;
            ARITH_SUB: alu = a - b;
            ARITH_AND: alu = a & b;
            ARITH_SHR: alu = a >> b[4:0];
            default:   ok = 1'b0;
          endcase
          if (!ok) begin
            r.fault = FAULT_UNSUP;
          end else begin
            write_gpr(rd, alu);
            npc = pc_now + 32'd4;
          end
        end
      endcase
    end
    pc_now    = npc;
    r.next_pc = npc;
    return r;
  endfunction

  function automatic logic [31:0] enc_op(input logic [3:0] pr, rd, input logic [31:0] kind,
                                         input logic [3:0] fn, ra, input logic use_imm,
                                         input logic [9:0] lo);
    return {pr, rd, 24'h0} | kind | {12'h0, fn, 16'h0} | {16'h0, ra, 12'h0}
           | (use_imm ? IMM_FLAG : 32'h0) | {22'h0, lo};
  endfunction

  function automatic logic [31:0] enc_upper(input logic [3:0] pr, rd, input logic [31:0] major,
                                            input logic [21:0] imm);
    return {pr, rd, 24'h0} | major | {10'h0, imm};
  endfunction

  // mostly well-formed instructions, stores usually aligned against the current base
  function automatic logic [31:0] random_instr();
    logic [3:0]  pr, rd, ra;
    logic [31:0] op;
    logic [9:0]  lo;
    logic [7:0]  short_off;
    int          pick;
    pr        = ($urandom_range(0, 9) < 6) ? P_ALWAYS : 4'($urandom);
    rd        = 4'($urandom);
    ra        = 4'($urandom);
    lo        = 10'($urandom);
    short_off = 8'($urandom);
    pick      = $urandom_range(0, 99);
    if (pick < 12) return enc_upper(pr, rd, MAJOR_LUI, 22'($urandom));
    if (pick < 20)
      return enc_upper(pr, rd, MAJOR_JUMP, ($urandom_range(0, 1) != 0) ?
                       {{14{short_off[7]}}, short_off} : 22'($urandom));
    if (pick < 27) return enc_op(pr, rd, CLASS_MISC, MISC_JR, ra, 1'($urandom), lo);
    if (pick < 45)
      return enc_op(pr, rd, CLASS_CMP, 4'($urandom_range(0, 3)), ra, 1'($urandom), lo);
    if (pick < 72) begin
      case ($urandom_range(0, 3))
        0:       op = ARITH_ADD;
        1:       op = ARITH_SUB;
        2:       op = ARITH_AND;
        default: op = ARITH_SHR;
      endcase
      return enc_op(pr, rd, op, 4'd0, ra, 1'($urandom), lo);
    end
    if (pick < 88) begin
      if ($urandom_range(0, 4) != 0)
        return enc_op(pr, 4'd0, CLASS_STORE, 4'($urandom), ra, 1'b1,
                      {lo[9:2], 2'b00} - {8'h0, gpr[ra][1:0]});
      return enc_op(pr, rd, CLASS_STORE, 4'($urandom), ra, 1'($urandom), lo);
    end
    return $urandom;
  endfunction

  task automatic send_instr(input logic [31:0] word);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.instruction <= word;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(execute_instr(word));
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_cycles   = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      hold_cycles = gaps_on ? $urandom_range(0, 9) : 0;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none got next_pc %h", $time, out_ch.next_pc);
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", want.next_pc, out_ch.next_pc);
        check_field("executed", {31'h0, want.executed}, {31'h0, out_ch.executed});
        check_field("store_valid", {31'h0, want.store_valid}, {31'h0, out_ch.store_valid});
        check_field("store_address", want.store_address, out_ch.store_address);
        check_field("store_data", want.store_data, out_ch.store_data);
        check_field("fault", {30'h0, want.fault}, {30'h0, out_ch.fault});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_alu_and_lui();
    send_instr(enc_upper(P_ALWAYS, 4'd1, MAJOR_LUI, 22'h3FFFFF));
    send_instr(enc_upper(P_ALWAYS, 4'd0, MAJOR_LUI, 22'h12345));
    send_instr(enc_op(P_ALWAYS, 4'd2, ARITH_ADD, 4'd0, 4'd1, 1'b1, 10'h200));
    send_instr(enc_op(P_ALWAYS, 4'd3, ARITH_SUB, 4'd0, 4'd0, 1'b0, 10'd1));
    send_instr(enc_op(P_ALWAYS, 4'd4, ARITH_AND, 4'd0, 4'd1, 1'b0, 10'd2));
    send_instr(enc_op(P_ALWAYS, 4'd5, ARITH_SHR, 4'd0, 4'd1, 1'b1, 10'h3FF));
  endtask

  task automatic test_compare_and_predication();
    send_instr(enc_op(P_ALWAYS, 4'd1, CLASS_CMP, CMP_GTS, 4'd3, 1'b0, 10'd1));
    send_instr(enc_op(P_ALWAYS, 4'b1010, CLASS_CMP, CMP_GTU, 4'd3, 1'b0, 10'd1));
    send_instr(enc_op(P_ALWAYS, 4'b1000, CLASS_CMP, CMP_EQ, 4'd0, 1'b0, 10'd0));
    send_instr(enc_op(P_ALWAYS, 4'd3, CLASS_CMP, CMP_BIT, 4'd1, 1'b1, 10'h3EA));
    // p1 is now set: plain predicate skips, inverted one runs
    send_instr(enc_op(4'b0001, 4'd7, ARITH_ADD, 4'd0, 4'd0, 1'b1, 10'h055));
    send_instr(enc_op(4'b1001, 4'd7, ARITH_ADD, 4'd0, 4'd0, 1'b1, 10'h055));
    send_instr(enc_op(P_NEVER, 4'd7, ARITH_ADD, 4'd0, 4'd0, 1'b1, 10'h0AA));
  endtask

  task automatic test_control_flow();
    send_instr(enc_upper(P_ALWAYS, 4'd8, MAJOR_JUMP, 22'h3FFFFF));
    send_instr(enc_upper(P_ALWAYS, 4'd0, MAJOR_JUMP, 22'h1FFFFF));
    send_instr(enc_upper(P_ALWAYS, 4'd9, MAJOR_JUMP, 22'h200000));
    send_instr(enc_upper(P_ALWAYS, 4'd10, MAJOR_LUI, 22'h000020));
    // unaligned target taken as is
    send_instr(enc_op(P_ALWAYS, 4'd11, CLASS_MISC, MISC_JR, 4'd7, 1'b1, 10'h0));
    send_instr(enc_op(P_ALWAYS, 4'd0, CLASS_MISC, MISC_JR, 4'd10, 1'b1, 10'h0));
  endtask

  task automatic test_stores();
    send_instr(enc_op(P_ALWAYS, 4'd0, CLASS_STORE, 4'd1, 4'd10, 1'b1, 10'h3FC));
    send_instr(enc_op(P_ALWAYS, 4'd0, CLASS_STORE, 4'd1, 4'd10, 1'b1, 10'h002));
    send_instr(enc_op(P_ALWAYS, 4'd5, CLASS_STORE, 4'd1, 4'd10, 1'b1, 10'h000));
  endtask

  task automatic test_faults();
    send_instr(enc_upper(P_ALWAYS, 4'd1, MAJOR_UPPER, 22'h0));
    send_instr(enc_op(P_ALWAYS, 4'd1, CLASS_CMP, CMP_BAD, 4'd1, 1'b0, 10'd2));
    send_instr(enc_op(P_ALWAYS, 4'd1, CLASS_MISC, MISC_BAD, 4'd1, 1'b0, 10'd2));
    send_instr(enc_op(P_ALWAYS, 4'd1, ARITH_BAD, 4'd0, 4'd1, 1'b0, 10'd2));
    send_instr(enc_op(P_ALWAYS, 4'd1, ARITH_BAD_HI, 4'd0, 4'd1, 1'b0, 10'd2));
  endtask

  task automatic test_output_stall();
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (20) send_instr(random_instr());
    gaps_on = 1'b1;
  endtask

  task automatic test_random_program();
    repeat (10) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (50) send_instr(random_instr());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.instruction = '0;
    out_ch.ready      = 1'b0;
    for (int k = 0; k < NUM_REGS; k++) gpr[k] = '0;
    pred_bits = '0;
    pc_now    = RESET_ADDR;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_alu_and_lui();
    test_compare_and_predication();
    test_control_flow();
    test_stores();
    test_faults();
    test_output_stall();
    test_random_program();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
